// ----- design/rwss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rwss_pkg;

	localparam int FRAC_BITS = 16;
	localparam int TEX_BITS  = 6;
	localparam int DIST_W    = 24;
	localparam int SLICE_W   = 16;
	localparam int TEXQ_W    = 23;
	localparam int H_W       = 12;
	localparam int RAY_W     = 19;
	localparam int OFS_W     = SLICE_W - 1;
	localparam int HIT_W     = 2 * FRAC_BITS;

	localparam int DIV_DW    = 24;
	localparam int DIV_QW    = 24;
	localparam int DIV_NW    = DIV_DW + DIV_QW;

	localparam logic [H_W-1:0]    H_RESET   = H_W'(1080);
	localparam logic [DIST_W-1:0] DIST_MAX  = '1;
	localparam logic [SLICE_W-1:0] SLICE_MAX = '1;
	localparam logic [TEXQ_W-1:0] TEXQ_MAX  = '1;
	localparam logic [DIV_NW-1:0] TEX_NUM   = DIV_NW'(64) << FRAC_BITS;

	typedef struct packed {
		logic                    force_max;
		logic                    force_zero;
		logic [FRAC_BITS-1:0]    eye_frac;
		logic signed [RAY_W-1:0] ray_other;
		logic                    mirror;
	} front_sb_t;

	typedef struct packed {
		logic [DIST_W-1:0]    wdist;
		logic [HIT_W-1:0]     prod;
		logic [FRAC_BITS-1:0] eye_frac;
		logic                 mirror;
		logic                 slice_sat;
		logic                 dist_zero;
	} slice_sb_t;

	typedef struct packed {
		logic [DIST_W-1:0]   wdist;
		logic [SLICE_W-1:0]  slice;
		logic [H_W-1:0]      first;
		logic [H_W-1:0]      last;
		logic [TEX_BITS-1:0] col;
		logic [OFS_W-1:0]    offset;
		logic                slice_zero;
		logic                degen;
	} tex_sb_t;

endpackage
`default_nettype wire

// ----- design/rwss_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rwss_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic [rwss_pkg::DIV_NW-1:0]  dividend,
	input  wire logic [rwss_pkg::DIV_DW-1:0]  divisor,
	output logic                              out_valid,
	output logic [rwss_pkg::DIV_QW-1:0]       quotient
);

	localparam int DW = rwss_pkg::DIV_DW;
	localparam int QW = rwss_pkg::DIV_QW;

	logic [DW-1:0] rem_s [0:QW];
	logic [QW-1:0] lo_s  [0:QW];
	logic [QW-1:0] quo_s [0:QW];
	logic [DW-1:0] dsr_s [0:QW];
	logic [QW:0]   vld_s;

	always_ff @(posedge clk) begin
		rem_s[0] <= dividend[DW+QW-1:QW];
		lo_s[0]  <= dividend[QW-1:0];
		quo_s[0] <= '0;
		dsr_s[0] <= divisor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[QW-1:0], in_valid};
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW:0]   r_ext;
		logic [DW+1:0] diff;
		assign r_ext = {rem_s[k], lo_s[k][QW-1]};
		assign diff  = {1'b0, r_ext} - {2'b0, dsr_s[k]};
		always_ff @(posedge clk) begin
			if (!diff[DW+1]) begin
				rem_s[k+1] <= diff[DW-1:0];
				quo_s[k+1] <= {quo_s[k][QW-2:0], 1'b1};
			end else begin
				rem_s[k+1] <= r_ext[DW-1:0];
				quo_s[k+1] <= {quo_s[k][QW-2:0], 1'b0};
			end
			lo_s[k+1]  <= {lo_s[k][QW-2:0], 1'b0};
			dsr_s[k+1] <= dsr_s[k];
		end
	end

	assign out_valid = vld_s[QW];
	assign quotient  = quo_s[QW];

endmodule
`default_nettype wire

// ----- design/rwss_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rwss_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	input  wire logic                               hit_side,
	input  wire logic [7:0]                         cell_x,
	input  wire logic [7:0]                         cell_y,
	input  wire logic [23:0]                        eye_x,
	input  wire logic [23:0]                        eye_y,
	input  wire logic signed [1:0]                  dir_sign_x,
	input  wire logic signed [1:0]                  dir_sign_y,
	input  wire logic signed [rwss_pkg::RAY_W-1:0]  ray_x,
	input  wire logic signed [rwss_pkg::RAY_W-1:0]  ray_y,
	output logic                                    valid_s1,
	output logic [rwss_pkg::DIV_NW-1:0]             dividend_s1,
	output logic [rwss_pkg::DIV_DW-1:0]             divisor_s1,
	output rwss_pkg::front_sb_t                     sb_s1
);

	localparam int F  = rwss_pkg::FRAC_BITS;
	localparam int RW = rwss_pkg::RAY_W;

	logic                 step_neg;
	logic [7:0]           hit_cell;
	logic [23:0]          eye;
	logic signed [RW-1:0] ray;
	logic signed [RW-1:0] ray_neg;
	logic [8:0]           cell_o;
	logic signed [25:0]   num;
	logic signed [25:0]   num_neg;
	logic [24:0]          mag;
	logic [RW-1:0]        den;
	logic                 ray_zero;
	logic                 num_zero;
	logic                 opposite;
	logic                 q_sat;
	logic                 mirror;

	always_comb begin
		step_neg = hit_side ? dir_sign_y[1] : dir_sign_x[1];
		hit_cell = hit_side ? cell_y : cell_x;
		eye      = hit_side ? eye_y : eye_x;
		ray      = hit_side ? ray_y : ray_x;
		cell_o   = {1'b0, hit_cell} + {8'b0, step_neg};
		num      = $signed({1'b0, cell_o, {F{1'b0}}}) - $signed({2'b0, eye});
		num_neg  = -num;
		mag      = num[25] ? num_neg[24:0] : num[24:0];
		ray_neg  = -ray;
		den      = ray[RW-1] ? ray_neg : ray;
		ray_zero = (ray == '0);
		num_zero = (num == '0);
		opposite = num[25] != ray[RW-1];
		q_sat    = {2'b0, mag} >= {den, 8'b0};
		mirror   = hit_side ? ray_y[RW-1] : (!ray_x[RW-1] && ray_x != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		dividend_s1        <= {7'b0, mag, {F{1'b0}}};
		divisor_s1         <= {5'b0, den};
		sb_s1.force_max    <= ray_zero || (!num_zero && !opposite && q_sat);
		sb_s1.force_zero   <= !ray_zero && (num_zero || opposite);
		sb_s1.eye_frac     <= hit_side ? eye_x[F-1:0] : eye_y[F-1:0];
		sb_s1.ray_other    <= hit_side ? ray_x : ray_y;
		sb_s1.mirror       <= mirror;
	end

endmodule
`default_nettype wire

// ----- design/raycast_wall_slice_setup_top.sv -----
// channel   | signals                                   | transfer when
// ----------+-------------------------------------------+-----------------------
// cfg       | cfg_valid, cfg_ready, cfg_data            | cfg_valid && cfg_ready
// item in   | start, busy, hit fields                   | start && !busy
// result    | done, result fields                       | every cycle done is high
//
// one item enters per cycle and one result leaves per cycle; the path runs through
// three 24-stage restoring dividers (one quotient bit per stage) plus setup,
// multiply and saturation stages. busy stays low and cfg_ready stays high.
// arst_n clears the valid bits and loads screen_height with 1080.
// the pipeline never stalls; each result is shown for one cycle only.
`timescale 1ns / 1ps
`default_nettype none
module raycast_wall_slice_setup_top (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [11:0]           cfg_data,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  hit_side,
	input  wire logic [7:0]            cell_x,
	input  wire logic [7:0]            cell_y,
	input  wire logic [23:0]           eye_x,
	input  wire logic [23:0]           eye_y,
	input  wire logic signed [1:0]     dir_sign_x,
	input  wire logic signed [1:0]     dir_sign_y,
	input  wire logic signed [18:0]    ray_x,
	input  wire logic signed [18:0]    ray_y,
	output logic                       done,
	output logic [23:0]                wall_distance,
	output logic [15:0]                slice_height,
	output logic [11:0]                first_row,
	output logic [11:0]                last_row,
	output logic [5:0]                 texture_column,
	output logic [22:0]                texture_step,
	output logic [22:0]                texture_start,
	output logic                       degenerate
);

	localparam int QW  = rwss_pkg::DIV_QW;
	localparam int F   = rwss_pkg::FRAC_BITS;
	localparam int HW  = rwss_pkg::H_W;
	localparam int DSW = rwss_pkg::DIST_W;
	localparam int SW  = rwss_pkg::SLICE_W;
	localparam int TW  = rwss_pkg::TEXQ_W;
	localparam int OW  = rwss_pkg::OFS_W;
	localparam int XB  = rwss_pkg::TEX_BITS;
	localparam int HTW = rwss_pkg::HIT_W;

	logic [HW-1:0] screen_height_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_height_q <= rwss_pkg::H_RESET;
		end else if (cfg_valid && cfg_ready) begin
			screen_height_q <= cfg_data;
		end
	end

	// stage 1: distance setup
	logic                           v_s1;
	logic [rwss_pkg::DIV_NW-1:0]    dvd_s1;
	logic [rwss_pkg::DIV_DW-1:0]    dsr_s1;
	rwss_pkg::front_sb_t            fsb_s1;

	rwss_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (start && !busy),
		.hit_side    (hit_side),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.eye_x       (eye_x),
		.eye_y       (eye_y),
		.dir_sign_x  (dir_sign_x),
		.dir_sign_y  (dir_sign_y),
		.ray_x       (ray_x),
		.ray_y       (ray_y),
		.valid_s1    (v_s1),
		.dividend_s1 (dvd_s1),
		.divisor_s1  (dsr_s1),
		.sb_s1       (fsb_s1)
	);

	// distance divider
	logic          dv1;
	logic [QW-1:0] q1;
	rwss_pkg::front_sb_t fsb_s [0:QW];

	rwss_div u_div_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.dividend  (dvd_s1),
		.divisor   (dsr_s1),
		.out_valid (dv1),
		.quotient  (q1)
	);

	always_ff @(posedge clk) begin
		fsb_s[0] <= fsb_s1;
		for (int k = 0; k < QW; k++) begin
			fsb_s[k+1] <= fsb_s[k];
		end
	end

	// stage 2: distance resolved
	logic                    v_s2;
	logic [DSW-1:0]          dist_s2;
	logic [F-1:0]            efr_s2;
	logic signed [18:0]      rot_s2;
	logic                    mir_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= dv1;
		end
	end

	always_ff @(posedge clk) begin
		if (fsb_s[QW].force_max) begin
			dist_s2 <= rwss_pkg::DIST_MAX;
		end else if (fsb_s[QW].force_zero) begin
			dist_s2 <= '0;
		end else begin
			dist_s2 <= q1[DSW-1:0];
		end
		efr_s2 <= fsb_s[QW].eye_frac;
		rot_s2 <= fsb_s[QW].ray_other;
		mir_s2 <= fsb_s[QW].mirror;
	end

	// slice divider, hit point product alongside
	logic signed [43:0]  prod2;
	rwss_pkg::slice_sb_t ssb_in;
	rwss_pkg::slice_sb_t ssb_s [0:QW];
	logic                dv2;
	logic [QW-1:0]       q2;

	always_comb begin
		prod2            = $signed({1'b0, dist_s2}) * rot_s2;
		ssb_in.wdist     = dist_s2;
		ssb_in.prod      = prod2[HTW-1:0];
		ssb_in.eye_frac  = efr_s2;
		ssb_in.mirror    = mir_s2;
		ssb_in.slice_sat = {12'b0, screen_height_q} >= dist_s2;
		ssb_in.dist_zero = (dist_s2 == '0);
	end

	rwss_div u_div_slice (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.dividend  ({20'b0, screen_height_q, {F{1'b0}}}),
		.divisor   (dist_s2),
		.out_valid (dv2),
		.quotient  (q2)
	);

	always_ff @(posedge clk) begin
		ssb_s[0] <= ssb_in;
		for (int k = 0; k < QW; k++) begin
			ssb_s[k+1] <= ssb_s[k];
		end
	end

	// stage 3: slice height and texture column
	logic           v_s3;
	logic [DSW-1:0] dist_s3;
	logic [SW-1:0]  slice_s3;
	logic [XB-1:0]  col_s3;
	logic           dz_s3;
	logic [HTW-1:0] hit_w;

	assign hit_w = {ssb_s[QW].eye_frac, {F{1'b0}}} + ssb_s[QW].prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= dv2;
		end
	end

	always_ff @(posedge clk) begin
		dist_s3  <= ssb_s[QW].wdist;
		slice_s3 <= ssb_s[QW].slice_sat ? rwss_pkg::SLICE_MAX : q2[SW-1:0];
		col_s3   <= ssb_s[QW].mirror ? ~hit_w[HTW-1 -: XB] : hit_w[HTW-1 -: XB];
		dz_s3    <= ssb_s[QW].dist_zero;
	end

	// stage 4: rows
	logic [HW-2:0]  half_h;
	logic [OW-1:0]  half_s;
	logic [SW-1:0]  row_sum;
	logic [HW-1:0]  h_m1;
	logic           v_s4;
	rwss_pkg::tex_sb_t tsb_s4;

	always_comb begin
		half_h  = screen_height_q[HW-1:1];
		half_s  = slice_s3[SW-1:1];
		row_sum = {1'b0, half_s} + {5'b0, half_h};
		h_m1    = (screen_height_q == '0) ? '0 : screen_height_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		tsb_s4.wdist      <= dist_s3;
		tsb_s4.slice      <= slice_s3;
		tsb_s4.first      <= ({4'b0, half_h} > half_s) ?
			HW'({4'b0, half_h} - half_s) : '0;
		tsb_s4.last       <= (row_sum > {4'b0, h_m1}) ? h_m1 : row_sum[HW-1:0];
		tsb_s4.col        <= col_s3;
		tsb_s4.offset     <= (half_s >= {4'b0, half_h}) ? half_s - {4'b0, half_h} : '0;
		tsb_s4.slice_zero <= (slice_s3 == '0);
		tsb_s4.degen      <= dz_s3 || (slice_s3 == '0);
	end

	// texture step divider
	rwss_pkg::tex_sb_t tsb_s [0:QW];
	logic              dv3;
	logic [QW-1:0]     q3;

	rwss_div u_div_tex (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.dividend  (rwss_pkg::TEX_NUM),
		.divisor   ({8'b0, tsb_s4.slice}),
		.out_valid (dv3),
		.quotient  (q3)
	);

	always_ff @(posedge clk) begin
		tsb_s[0] <= tsb_s4;
		for (int k = 0; k < QW; k++) begin
			tsb_s[k+1] <= tsb_s[k];
		end
	end

	// stage 5: texture step, stage 6: start product, stage 7: output
	logic              v_s5, v_s6, v_s7;
	rwss_pkg::tex_sb_t tsb_s5, tsb_s6, tsb_s7;
	logic [TW-1:0]     step_s5, step_s6, step_s7, start_s7;
	logic [OW+TW-1:0]  prod_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s5 <= dv3;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		tsb_s5  <= tsb_s[QW];
		step_s5 <= tsb_s[QW].slice_zero ? rwss_pkg::TEXQ_MAX : q3[TW-1:0];
		tsb_s6  <= tsb_s5;
		step_s6 <= step_s5;
		prod_s6 <= tsb_s5.offset * step_s5;
		tsb_s7  <= tsb_s6;
		step_s7 <= step_s6;
		if (tsb_s6.slice_zero || prod_s6 > {{OW{1'b0}}, rwss_pkg::TEXQ_MAX}) begin
			start_s7 <= rwss_pkg::TEXQ_MAX;
		end else begin
			start_s7 <= prod_s6[TW-1:0];
		end
	end

	assign done           = v_s7;
	assign wall_distance  = tsb_s7.wdist;
	assign slice_height   = tsb_s7.slice;
	assign first_row      = tsb_s7.first;
	assign last_row       = tsb_s7.last;
	assign texture_column = tsb_s7.col;
	assign texture_step   = step_s7;
	assign texture_start  = start_s7;
	assign degenerate     = tsb_s7.degen;

	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (degenerate == (wall_distance == '0 || slice_height == '0)))
		else $error("degenerate flag disagrees with distance and slice");

	a_rows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (first_row <= last_row))
		else $error("first row past last row");

	a_zero_slice: assert property (@(posedge clk) disable iff (!arst_n)
		(done && slice_height == '0) |->
		(texture_step == rwss_pkg::TEXQ_MAX && texture_start == rwss_pkg::TEXQ_MAX))
		else $error("zero slice did not saturate texture fields");

	a_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(done && wall_distance == '0) |-> (slice_height == rwss_pkg::SLICE_MAX))
		else $error("zero distance did not saturate slice height");

endmodule
`default_nettype wire

// ----- test/tb_raycast_wall_slice_setup_top.sv -----
`timescale 1ns / 1ps
module tb_raycast_wall_slice_setup_top;

	typedef struct {
		logic [23:0] wdist;
		logic [15:0] slice;
		logic [11:0] first;
		logic [11:0] last;
		logic [5:0]  col;
		logic [22:0] tstep;
		logic [22:0] tstart;
		logic        degen;
	} slice_setup_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [11:0] cfg_data = '0;
	logic start = 1'b0;
	logic busy;
	logic hit_side = 1'b0;
	logic [7:0] cell_x = '0;
	logic [7:0] cell_y = '0;
	logic [23:0] eye_x = '0;
	logic [23:0] eye_y = '0;
	logic signed [1:0] dir_sign_x = '0;
	logic signed [1:0] dir_sign_y = '0;
	logic signed [18:0] ray_x = '0;
	logic signed [18:0] ray_y = '0;
	logic done;
	logic [23:0] wall_distance;
	logic [15:0] slice_height;
	logic [11:0] first_row;
	logic [11:0] last_row;
	logic [5:0] texture_column;
	logic [22:0] texture_step;
	logic [22:0] texture_start;
	logic degenerate;

	logic [11:0] rows_cfg = rwss_pkg::H_RESET;
	slice_setup_t pending_slices[$];
	int errors = 0;
	int sender_idle_pct = 0;
	longint cycles = 0;

	raycast_wall_slice_setup_top u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.start(start), .busy(busy),
		.hit_side(hit_side), .cell_x(cell_x), .cell_y(cell_y),
		.eye_x(eye_x), .eye_y(eye_y), .dir_sign_x(dir_sign_x), .dir_sign_y(dir_sign_y),
		.ray_x(ray_x), .ray_y(ray_y),
		.done(done), .wall_distance(wall_distance), .slice_height(slice_height),
		.first_row(first_row), .last_row(last_row), .texture_column(texture_column),
		.texture_step(texture_step), .texture_start(texture_start),
		.degenerate(degenerate)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("tb_raycast_wall_slice_setup_top NOT OK");
			$finish;
		end
	end

	function automatic longint unsigned wall_dist(longint unsigned hit_cell,
			longint unsigned eye, logic [1:0] stp, longint ray);
		longint num;
		longint unsigned mag, den, q;
		num = longint'((hit_cell + stp[1]) << rwss_pkg::FRAC_BITS) - longint'(eye);
		if (ray == 0)
			return 64'hFFFFFF;
		if (num == 0 || ((num < 0) != (ray < 0)))
			return 0;
		mag = num < 0 ? -num : num;
		den = ray < 0 ? -ray : ray;
		q = (mag << rwss_pkg::FRAC_BITS) / den;
		return q > 64'hFFFFFF ? 64'hFFFFFF : q;
	endfunction

	function automatic slice_setup_t project_slice(logic side, logic [7:0] cx, logic [7:0] cy,
			logic [23:0] ex, logic [23:0] ey, logic [1:0] sx, logic [1:0] sy,
			logic signed [18:0] rx, logic signed [18:0] ry, logic [11:0] rows);
		slice_setup_t r;
		longint unsigned h, wd, slice, half_h, half_s, first, ts, tst, col, w;
		longint last;
		logic degen;
		h = rows;
		degen = 1'b0;
		wd = side ? wall_dist(cy, ey, sy, longint'(ry)) : wall_dist(cx, ex, sx, longint'(rx));
		if (wd == 0) begin
			slice = 64'hFFFF;
			degen = 1'b1;
		end else begin
			slice = (h << rwss_pkg::FRAC_BITS) / wd;
			if (slice > 64'hFFFF)
				slice = 64'hFFFF;
		end
		half_h = h >> 1;
		half_s = slice >> 1;
		first = half_h > half_s ? half_h - half_s : 0;
		last = longint'(half_s + half_h);
		if (last > longint'(h) - 1)
			last = longint'(h) - 1;
		if (last < 0)
			last = 0;
		if (side)
			w = (64'(ex) << rwss_pkg::FRAC_BITS) + longint'(wd) * longint'(rx);
		else
			w = (64'(ey) << rwss_pkg::FRAC_BITS) + longint'(wd) * longint'(ry);
		col = ((w & 64'hFFFF_FFFF) * 64) >> 32;
		if ((!side && rx > 0) || (side && ry < 0))
			col = 63 - col;
		if (slice == 0) begin
			ts = 64'h7FFFFF;
			tst = 64'h7FFFFF;
			degen = 1'b1;
		end else begin
			ts = (64'd64 << rwss_pkg::FRAC_BITS) / slice;
			if (ts > 64'h7FFFFF)
				ts = 64'h7FFFFF;
			tst = (first + half_s - half_h) * ts;
			if (tst > 64'h7FFFFF)
				tst = 64'h7FFFFF;
		end
		r.wdist = wd[23:0];
		r.slice = slice[15:0];
		r.first = first[11:0];
		r.last = last[11:0];
		r.col = col[5:0];
		r.tstep = ts[22:0];
		r.tstart = tst[22:0];
		r.degen = degen;
		return r;
	endfunction

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			$display("%0t %s expected %0d actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		slice_setup_t e;
		if (arst_n && done) begin
			if (pending_slices.size() == 0) begin
				$display("%0t unexpected result expected none actual dist %0d", $time,
					wall_distance);
				errors++;
			end else begin
				e = pending_slices.pop_front();
				check_field("wall_distance", e.wdist, wall_distance);
				check_field("slice_height", e.slice, slice_height);
				check_field("first_row", e.first, first_row);
				check_field("last_row", e.last, last_row);
				check_field("texture_column", e.col, texture_column);
				check_field("texture_step", e.tstep, texture_step);
				check_field("texture_start", e.tstart, texture_start);
				check_field("degenerate", e.degen, degenerate);
			end
		end
	end

	// start stays high across back-to-back transfers
	task automatic send_hit(logic side, logic [7:0] cx, logic [7:0] cy, logic [23:0] ex,
			logic [23:0] ey, logic [1:0] sx, logic [1:0] sy, logic [18:0] rx, logic [18:0] ry);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		hit_side <= side;
		cell_x <= cx;
		cell_y <= cy;
		eye_x <= ex;
		eye_y <= ey;
		dir_sign_x <= sx;
		dir_sign_y <= sy;
		ray_x <= rx;
		ray_y <= ry;
		do
			@(posedge clk);
		while (busy);
		pending_slices.push_back(project_slice(side, cx, cy, ex, ey, sx, sy, rx, ry, rows_cfg));
	endtask

	task automatic set_rows(logic [11:0] v);
		start <= 1'b0;
		@(posedge clk);
		while (pending_slices.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		rows_cfg = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed();
		send_hit(0, 0, 0, 0, 0, 2'sb01, 2'sb01, 19'sd65536, 19'sd0);
		send_hit(1, 255, 255, 24'hFFFFFF, 24'hFFFFFF, 2'sb11, 2'sb11, -19'sd65536, 19'sd1);
		send_hit(0, 5, 3, 24'h028000, 24'h031234, 2'sb01, 2'sb01, 19'sd0, 19'sd100);
		send_hit(0, 5, 3, 24'h050000, 24'h031234, 2'sb01, 2'sb01, 19'sd40000, 19'sd100);
		send_hit(1, 5, 3, 24'h021234, 24'h050000, 2'sb01, 2'sb01, 19'sd100, -19'sd40000);
		send_hit(0, 9, 3, 24'h028000, 24'h031234, 2'sb01, 2'sb01, -19'sd65536, 19'sd500);
		send_hit(0, 200, 3, 24'h010000, 24'h031234, 2'sb01, 2'sb01, 19'sd1, 19'sd7);
		send_hit(0, 9, 3, 24'h028000, 24'h031234, 2'sb00, 2'sb10, 19'sd65536, 19'sd500);
		send_hit(0, 2, 3, 24'h038000, 24'h031234, 2'sb10, 2'sb00, -19'sd65536, -19'sd500);
		send_hit(1, 2, 9, 24'h038000, 24'h031234, 2'sb00, 2'sb00, 19'sd3000, 19'sd65536);
		send_hit(1, 2, 2, 24'h038000, 24'h031234, 2'sb11, 2'sb10, -19'sd3000, -19'sd65536);
		send_hit(0, 4, 0, 24'h03FFFF, 0, 2'sb01, 2'sb01, -19'sd262144, 19'sd262143);
		send_hit(1, 0, 4, 24'hFFFFFF, 24'h03FFFF, 2'sb01, 2'sb01, 19'sd262143, -19'sd262144);
		send_hit(0, 10, 0, 24'h09FFFF, 0, 2'sb01, 2'sb01, 19'sd65536, 19'sd65536);
		send_hit(0, 3, 0, 24'h02F000, 24'h123456, 2'sb01, 2'sb01, 19'sd262143, 19'sd1234);
	endtask

	task automatic test_random(int count);
		logic side;
		logic [7:0] cx, cy;
		logic [23:0] ex, ey;
		logic [1:0] sx, sy;
		logic [18:0] rx, ry;
		for (int i = 0; i < count; i++) begin
			side = 1'($urandom_range(1));
			ex = 24'($urandom);
			ey = 24'($urandom);
			rx = 19'($urandom);
			ry = 19'($urandom);
			sx = 2'($urandom);
			sy = 2'($urandom);
			cx = 8'($urandom);
			cy = 8'($urandom);
			if ($urandom_range(9) < 8) begin
				// hit cell a few cells ahead along the ray, as a DDA walk would find
				rx = 19'($urandom_range(1, 90000));
				ry = 19'($urandom_range(1, 90000));
				if ($urandom_range(1))
					rx = -rx;
				if ($urandom_range(1))
					ry = -ry;
				sx = rx[18] ? 2'sb11 : 2'sb01;
				sy = ry[18] ? 2'sb11 : 2'sb01;
				cx = 8'(ex[23:16] + (rx[18] ? -$urandom_range(0, 12) : $urandom_range(0, 12)));
				cy = 8'(ey[23:16] + (ry[18] ? -$urandom_range(0, 12) : $urandom_range(0, 12)));
			end
			send_hit(side, cx, cy, ex, ey, sx, sy, rx, ry);
		end
	endtask

	task automatic test_screen_heights();
		set_rows(12'd4095);
		test_directed();
		test_random(60);
		set_rows(12'd2);
		test_random(60);
		set_rows(12'd0);
		test_random(20);
		set_rows(12'd1);
		test_random(20);
		set_rows(12'($urandom_range(2, 4095)));
		test_random(60);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sender_idle_pct = 0;
		test_directed();
		test_random(300);
		sender_idle_pct = 86;
		test_random(250);
		test_screen_heights();
		set_rows(12'd1080);
		sender_idle_pct = 6;
		test_random(300);
		sender_idle_pct = 0;
		test_random(100);
		start <= 1'b0;
		while (pending_slices.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("tb_raycast_wall_slice_setup_top OK");
		else
			$display("tb_raycast_wall_slice_setup_top NOT OK");
		$finish;
	end

endmodule

// ----- sim.f -----
design/rwss_pkg.sv
design/rwss_div.sv
design/rwss_front.sv
design/raycast_wall_slice_setup_top.sv
test/tb_raycast_wall_slice_setup_top.sv
